// ===== rtl/gad_pkg.sv =====
// Shared types, constants and pipeline stage functions for the spiral point generator.
`timescale 1ns / 1ps
package gad_pkg;

  localparam logic [6:0]  MAX_RAYS     = 7'd64;
  localparam logic [30:0] GOLDEN_TURNS = 31'd1640531527;
  localparam logic [16:0] SIN_A        = 17'd102944;
  localparam logic [16:0] SIN_B        = 17'd42047;
  localparam logic [16:0] SIN_C        = 17'd4640;
  localparam logic [16:0] SIN_ONE      = 17'd65536;
  localparam int          DIV_STAGES   = 5;
  localparam int          SQRT_STAGES  = 8;
  localparam int          PIPE_DEPTH   = 23;

  typedef enum logic [1:0] {
    REG_RAY_COUNT   = 2'd0,
    REG_DISK_RADIUS = 2'd1,
    REG_SPIN_RATE   = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]         idx;
    logic               last;
    logic [6:0]         n;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic [31:0]        tim;
    logic [21:0]        t;
    logic [39:0]        num;
    logic [5:0]         rem;
    logic [31:0]        quo;
    logic [31:0]        sx;
    logic [31:0]        sr;
    logic [23:0]        rad;
    logic [1:0]         quad;
    logic [16:0]        vs;
    logic [16:0]        vc;
    logic [16:0]        x2s;
    logic [16:0]        x2c;
    logic [16:0]        ps;
    logic [16:0]        pc;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
  } pt_t;

  // phase from time and spin, then the dividend t << 16
  function automatic pt_t st_phase(pt_t a, logic [15:0] spin);
    logic [47:0] prod;
    pt_t b;
    b = a;
    prod = 48'(a.tim) * 48'(spin);
    b.t = {a.idx, prod[23:8]};
    b.num = {2'b00, a.idx, prod[23:8], 16'h0000};
    b.rem = '0;
    b.quo = '0;
    return b;
  endfunction

  // eight quotient bits of (t << 16) / n
  function automatic pt_t st_div(pt_t a);
    logic [6:0] r7;
    logic       ge;
    pt_t b;
    b = a;
    for (int j = 0; j < 8; j++) begin
      r7 = {b.rem, b.num[39]};
      b.num = {b.num[38:0], 1'b0};
      ge = (r7 >= b.n);
      if (ge) begin
        b.rem = 6'(r7 - b.n);
      end else begin
        b.rem = r7[5:0];
      end
      b.quo = {b.quo[30:0], ge};
    end
    return b;
  endfunction

  // two digits of the integer square root; stage s counts from 0
  function automatic pt_t st_sqrt(pt_t a, int s);
    logic [32:0] bitv;
    logic [32:0] sum;
    pt_t b;
    b = a;
    if (s == 0) begin
      b.sx = a.quo;
      b.sr = '0;
    end
    for (int j = 0; j < 2; j++) begin
      bitv = 33'(1) << (30 - 2 * (2 * s + j));
      sum = {1'b0, b.sr} + bitv;
      if ({1'b0, b.sx} >= sum) begin
        b.sx = b.sx - sum[31:0];
        b.sr = (b.sr >> 1) + bitv[31:0];
      end else begin
        b.sr = b.sr >> 1;
      end
    end
    return b;
  endfunction

  // radius scale and spiral angle
  function automatic pt_t st_angle(pt_t a, logic [15:0] radius);
    logic [31:0] rp;
    logic [52:0] ang;
    pt_t b;
    b = a;
    rp = 32'(radius) * 32'(a.sr[15:0]);
    b.rad = rp[31:8];
    ang = 53'(a.t) * 53'(GOLDEN_TURNS);
    b.quad = ang[47:46];
    b.vs = {1'b0, ang[45:30]};
    b.vc = SIN_ONE - {1'b0, ang[45:30]};
    return b;
  endfunction

  function automatic logic [16:0] sq16(logic [16:0] v, logic [16:0] w);
    logic [33:0] p;
    p = 34'(v) * 34'(w);
    return 17'(p >> 16);
  endfunction

  function automatic pt_t st_x2(pt_t a);
    pt_t b;
    b = a;
    b.x2s = sq16(a.vs, a.vs);
    b.x2c = sq16(a.vc, a.vc);
    return b;
  endfunction

  function automatic pt_t st_p1(pt_t a);
    pt_t b;
    b = a;
    b.ps = SIN_B - sq16(a.x2s, SIN_C);
    b.pc = SIN_B - sq16(a.x2c, SIN_C);
    return b;
  endfunction

  function automatic pt_t st_p2(pt_t a);
    pt_t b;
    b = a;
    b.ps = SIN_A - sq16(a.x2s, a.ps);
    b.pc = SIN_A - sq16(a.x2c, a.pc);
    return b;
  endfunction

  function automatic logic signed [15:0] sine_fin(logic [16:0] v, logic [16:0] p);
    logic [16:0] s;
    logic [16:0] q;
    s = sq16(v, p);
    if (s > SIN_ONE) begin
      s = SIN_ONE;
    end
    q = (s + 17'd2) >> 2;
    return signed'(q[15:0]);
  endfunction

  // finish both quarter sines and fold in the quadrant
  function automatic pt_t st_sine(pt_t a);
    logic signed [15:0] su;
    logic signed [15:0] sc;
    pt_t b;
    b = a;
    su = sine_fin(a.vs, a.ps);
    sc = sine_fin(a.vc, a.pc);
    case (a.quad)
      2'd0: begin
        b.sn = su;
        b.cs = sc;
      end
      2'd1: begin
        b.sn = sc;
        b.cs = -su;
      end
      2'd2: begin
        b.sn = -su;
        b.cs = -sc;
      end
      default: begin
        b.sn = -sc;
        b.cs = su;
      end
    endcase
    return b;
  endfunction

  function automatic pt_t st_comb(pt_t a);
    pt_t b;
    b = a;
    b.mx = a.rx * a.cs + a.ux * a.sn;
    b.my = a.ry * a.cs + a.uy * a.sn;
    b.mz = a.rz * a.cs + a.uz * a.sn;
    return b;
  endfunction

  function automatic logic signed [31:0] off_of(logic signed [31:0] c, logic [23:0] rad);
    logic        neg;
    logic [31:0] mag;
    logic [55:0] prod;
    logic signed [31:0] off;
    neg = c[31];
    mag = neg ? 32'(-c) : 32'(c);
    prod = 56'(mag) * 56'(rad) + 56'h800_0000;
    // drop the 28 fraction bits of the Q.28 by Q8.16 product
    off = signed'({4'b0000, prod[55:28]});
    return neg ? -off : off;
  endfunction

  function automatic pt_t st_off(pt_t a);
    pt_t b;
    b = a;
    b.mx = off_of(a.mx, a.rad);
    b.my = off_of(a.my, a.rad);
    b.mz = off_of(a.mz, a.rad);
    return b;
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] c,
                                                 logic signed [31:0] o);
    logic signed [32:0] s;
    s = 33'(c) + 33'(o);
    if (s > 33'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -33'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  function automatic pt_t st_sum(pt_t a);
    pt_t b;
    b = a;
    b.mx = sat_add(a.cx, a.mx);
    b.my = sat_add(a.cy, a.my);
    b.mz = sat_add(a.cz, a.mz);
    return b;
  endfunction

endpackage

// ===== rtl/gad_pipe.sv =====
// Point pipeline: phase, divider, square root, sine, projection and output register.
`timescale 1ns / 1ps
module gad_pipe import gad_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               issue_valid,
  input  pt_t                issue,
  input  logic [15:0]        disk_radius,
  input  logic [15:0]        spin_rate,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [5:0]         point_index,
  output logic               last_point
);

  pt_t                   pipe [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] vld;

  // the whole pipe moves together; hold everything while the output beat waits
  assign adv = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[PIPE_DEPTH-2:0], issue_valid};
      out_valid <= vld[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= issue;
      pipe[1] <= st_phase(pipe[0], spin_rate);
      for (int k = 0; k < DIV_STAGES; k++) begin
        pipe[2 + k] <= st_div(pipe[1 + k]);
      end
      for (int k = 0; k < SQRT_STAGES; k++) begin
        pipe[7 + k] <= st_sqrt(pipe[6 + k], k);
      end
      pipe[15] <= st_angle(pipe[14], disk_radius);
      pipe[16] <= st_x2(pipe[15]);
      pipe[17] <= st_p1(pipe[16]);
      pipe[18] <= st_p2(pipe[17]);
      pipe[19] <= st_sine(pipe[18]);
      pipe[20] <= st_comb(pipe[19]);
      pipe[21] <= st_off(pipe[20]);
      pipe[22] <= st_sum(pipe[21]);
      point_x     <= pipe[22].mx;
      point_y     <= pipe[22].my;
      point_z     <= pipe[22].mz;
      point_index <= pipe[22].idx;
      last_point  <= pipe[22].last;
    end
  end

endmodule

// ===== rtl/golden_angle_disk_ray_origins.sv =====
// Golden-angle spiral disk sampler: config registers, point sequencer and pipeline.
// The first point of a request passes the request register, the pipe and the output register.
// Throughput: one point per cycle while out_stall lets the pipe advance; a request of n points
// holds the input until its last point issues; a single issue slot feeds the 23-stage pipeline.
// The next request is taken in the cycle its predecessor issues its last point.
// Reset (synchronous) restores ray_count 16, disk_radius 256, spin_rate 256 and empties the pipe.
`timescale 1ns / 1ps
module golden_angle_disk_ray_origins import gad_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  input  logic signed [15:0] right_z,
  input  logic signed [15:0] up_x,
  input  logic signed [15:0] up_y,
  input  logic signed [15:0] up_z,
  input  logic [31:0]        time_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [5:0]         point_index,
  output logic               last_point
);

  logic [6:0]  ray_count;
  logic [15:0] disk_radius;
  logic [15:0] spin_rate;
  reg_idx_t    reg_sel;

  logic        busy;
  logic        busy_next;
  logic [5:0]  cnt;
  logic [5:0]  cnt_next;
  logic [6:0]  n;
  logic [6:0]  n_eff;
  pt_t         item;
  pt_t         item_next;
  pt_t         issue;
  logic        adv;
  logic        last_issue;
  logic        accept;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_count   <= 7'd16;
      disk_radius <= 16'd256;
      spin_rate   <= 16'd256;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_RAY_COUNT:   ray_count   <= pwdata[6:0];
        REG_DISK_RADIUS: disk_radius <= pwdata[15:0];
        REG_SPIN_RATE:   spin_rate   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RAY_COUNT:   prdata = {25'd0, ray_count};
      REG_DISK_RADIUS: prdata = {16'd0, disk_radius};
      REG_SPIN_RATE:   prdata = {16'd0, spin_rate};
      default:         prdata = '0;
    endcase
  end

  assign n_eff      = (ray_count > MAX_RAYS) ? MAX_RAYS : ray_count;
  assign last_issue = ({1'b0, cnt} == n - 7'd1);
  assign in_stall   = busy && !(adv && last_issue);
  assign accept     = in_valid && !in_stall;

  always_comb begin
    busy_next = busy;
    cnt_next  = cnt;
    if (busy && adv) begin
      if (last_issue) begin
        busy_next = 1'b0;
      end else begin
        cnt_next = cnt + 6'd1;
      end
    end
    // a zero count drops the request
    if (accept && n_eff != 7'd0) begin
      busy_next = 1'b1;
      cnt_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      busy <= busy_next;
      cnt  <= cnt_next;
    end
  end

  always_comb begin
    item_next     = '0;
    item_next.cx  = center_x;
    item_next.cy  = center_y;
    item_next.cz  = center_z;
    item_next.rx  = right_x;
    item_next.ry  = right_y;
    item_next.rz  = right_z;
    item_next.ux  = up_x;
    item_next.uy  = up_y;
    item_next.uz  = up_z;
    item_next.tim = time_now;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n    <= n_eff;
      item <= item_next;
    end
  end

  always_comb begin
    issue      = item;
    issue.idx  = cnt;
    issue.last = last_issue;
    issue.n    = n;
  end

  gad_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (busy),
    .issue       (issue),
    .disk_radius (disk_radius),
    .spin_rate   (spin_rate),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_index (point_index),
    .last_point  (last_point)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the golden-angle spiral disk sampler.
`timescale 1ns / 1ps
module tb_top;
  import gad_pkg::*;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic signed [15:0] rx, ry, rz, ux, uy, uz;
    logic [31:0]        tim;
  } disk_req_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [5:0]         idx;
    logic               last;
  } spiral_point_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 30;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] center_x, center_y, center_z;
  logic signed [15:0] right_x, right_y, right_z, up_x, up_y, up_z;
  logic [31:0] time_now;
  logic signed [31:0] point_x, point_y, point_z;
  logic [5:0] point_index;
  logic last_point;

  logic [6:0]  cfg_rays;
  logic [15:0] cfg_radius;
  logic [15:0] cfg_spin;

  spiral_point_t pending_points[$];
  int errors;
  int idle_cycles;
  int stall_left;
  bit calm;

  golden_angle_disk_ray_origins dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint quarter_sine(longint unsigned v);
    longint unsigned x2, p, s;
    x2 = (v * v) >> 16;
    p = 64'd42047 - ((x2 * 64'd4640) >> 16);
    p = 64'd102944 - ((x2 * p) >> 16);
    s = (v * p) >> 16;
    if (s > 64'd65536) s = 64'd65536;
    return longint'((s + 64'd2) >> 2);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 30;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] axis_pos(logic signed [31:0] c,
      logic signed [15:0] r, logic signed [15:0] u, longint cs, longint sn,
      longint unsigned rad);
    longint comb, off, p;
    longint unsigned mag;
    comb = longint'(r) * cs + longint'(u) * sn;
    mag = (comb < 0) ? longint'(-comb) : comb;
    off = longint'((mag * rad + (64'd1 << 27)) >> 28);
    p = longint'(c) + ((comb < 0) ? -off : off);
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  // queue every point of one request under the current register settings
  function automatic void spiral_points(disk_req_t d);
    longint unsigned n, phase, t, rad, a, u;
    longint su, sc, sn, cs;
    spiral_point_t pt;
    n = (cfg_rays > 64) ? 64 : cfg_rays;
    phase = ((64'(d.tim) * 64'(cfg_spin)) >> 8) & 64'hFFFF;
    for (longint unsigned i = 0; i < n; i++) begin
      t = (i << 16) | phase;
      rad = (64'(cfg_radius) * root_floor((t << 16) / n)) >> 8;
      a = (t * 64'd1640531527) & 64'hFFFF_FFFF_FFFF;
      u = (a >> 30) & 64'hFFFF;
      su = quarter_sine(u);
      sc = quarter_sine(64'd65536 - u);
      case (a >> 46)
        0: begin sn = su;  cs = sc;  end
        1: begin sn = sc;  cs = -su; end
        2: begin sn = -su; cs = -sc; end
        default: begin sn = -sc; cs = su; end
      endcase
      pt.x = axis_pos(d.cx, d.rx, d.ux, cs, sn, rad);
      pt.y = axis_pos(d.cy, d.ry, d.uy, cs, sn, rad);
      pt.z = axis_pos(d.cz, d.rz, d.uz, cs, sn, rad);
      pt.idx = i[5:0];
      pt.last = (i == n - 1);
      pending_points.push_back(pt);
    end
  endfunction

  function automatic logic signed [15:0] rand_axis();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic disk_req_t rand_disk();
    disk_req_t d;
    d.cx = $urandom; d.cy = $urandom; d.cz = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      d.cx = $signed(d.cx) >>> 8; d.cy = $signed(d.cy) >>> 8; d.cz = $signed(d.cz) >>> 8;
    end
    d.rx = rand_axis(); d.ry = rand_axis(); d.rz = rand_axis();
    d.ux = rand_axis(); d.uy = rand_axis(); d.uz = rand_axis();
    d.tim = $urandom;
    return d;
  endfunction

  task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (r)
      REG_RAY_COUNT:   cfg_rays = v[6:0];
      REG_DISK_RADIUS: cfg_radius = v[15:0];
      REG_SPIN_RATE:   cfg_spin = v[15:0];
      default: ;
    endcase
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_disk(input disk_req_t d);
    int gap;
    center_x <= d.cx; center_y <= d.cy; center_z <= d.cz;
    right_x <= d.rx; right_y <= d.ry; right_z <= d.rz;
    up_x <= d.ux; up_y <= d.uy; up_z <= d.uz;
    time_now <= d.tim;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    spiral_points(d);
    gap = calm ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold until every expected point is back and the pipe has settled
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_extremes();
    disk_req_t d;
    d.cx = 32'sh7FFF_FFFF; d.cy = 32'sh8000_0000; d.cz = 0;
    d.rx = 16384; d.ry = -16384; d.rz = 0;
    d.ux = 16384; d.uy = -16384; d.uz = 16384;
    d.tim = 0;
    send_disk(d);
    d.cx = 32'sh8000_0000; d.cy = 32'sh7FFF_FFFF; d.tim = 32'hFFFF_FFFF;
    send_disk(d);
    d.rx = 16'sh7FFF; d.ry = 16'sh8000; d.rz = 16'sh7FFF;
    d.ux = 16'sh8000; d.uy = 16'sh7FFF; d.uz = 16'sh8000;
    d.cx = 0; d.cy = 0; d.cz = 32'sh7FFF_FFFF; d.tim = 32'h0001_8000;
    send_disk(d);
    drain();
  endtask

  task automatic test_config_sweep();
    reg_write(REG_RAY_COUNT, 1);
    reg_write(REG_DISK_RADIUS, 16'hFFFF);
    reg_write(REG_SPIN_RATE, 16'hFFFF);
    repeat (3) send_disk(rand_disk());
    drain();
    reg_write(REG_RAY_COUNT, 64);
    reg_write(REG_DISK_RADIUS, 0);
    reg_write(REG_SPIN_RATE, 0);
    repeat (2) send_disk(rand_disk());
    drain();
    // above the ceiling of 64 points
    reg_write(REG_RAY_COUNT, 127);
    reg_write(REG_DISK_RADIUS, 16'hFFFF);
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    repeat (2) send_disk(rand_disk());
    drain();
    // zero points: requests are taken but yield nothing
    reg_write(REG_RAY_COUNT, 0);
    repeat (3) send_disk(rand_disk());
    drain();
    reg_write(REG_RAY_COUNT, 2);
    send_disk(rand_disk());
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph % 4 == 3);
      reg_write(REG_RAY_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 12));
      reg_write(REG_DISK_RADIUS, $urandom_range(0, 65535));
      reg_write(REG_SPIN_RATE, $urandom_range(0, 65535));
      repeat (15) send_disk(rand_disk());
      drain();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm) stall_left <= pause_len();
    end
  end

  always @(posedge clk) begin
    spiral_point_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: point beat with none expected: idx %0d", $time, point_index);
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (point_x !== e.x) begin
          $display("%0t: point_x expected %0d actual %0d", $time, e.x, point_x);
          errors++;
        end
        if (point_y !== e.y) begin
          $display("%0t: point_y expected %0d actual %0d", $time, e.y, point_y);
          errors++;
        end
        if (point_z !== e.z) begin
          $display("%0t: point_z expected %0d actual %0d", $time, e.z, point_z);
          errors++;
        end
        if (point_index !== e.idx) begin
          $display("%0t: point_index expected %0d actual %0d", $time, e.idx, point_index);
          errors++;
        end
        if (last_point !== e.last) begin
          $display("%0t: last_point expected %0d actual %0d", $time, e.last, last_point);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; stall_left = 0; calm = 1'b0;
    cfg_rays = 16; cfg_radius = 256; cfg_spin = 256;
    rst = 1'b1; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    center_x = '0; center_y = '0; center_z = '0;
    right_x = '0; right_y = '0; right_z = '0;
    up_x = '0; up_y = '0; up_z = '0; time_now = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_config_sweep();
    test_random();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== golden_angle_disk_ray_origins.f =====
rtl/gad_pkg.sv
rtl/gad_pipe.sv
rtl/golden_angle_disk_ray_origins.sv
tb/tb_top.sv
